[rtl/pat_pkg.sv]
// Shared types and constants for the periodic alarm timer.
// No dependencies; every other file of the block but pat_stream_if imports this package.
`default_nettype none

package pat_pkg;

    // Parameter defaults
    localparam int CHANNELS_DEFAULT      = 2;
    localparam int COUNTER_WIDTH_DEFAULT = 32;

    // Fixed field and register widths
    localparam int REG_WIDTH      = 32;
    localparam int PULSE_REGS     = 2;
    localparam int MASK_WIDTH     = 2;
    localparam int CMD_WIDTH      = 3;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int COUNT_OUT_BITS = 32;

    // Command codes
    localparam logic [CMD_WIDTH-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_STOP     = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR    = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_SHUTDOWN = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEFAULT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CHANNEL0_PULSE  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CHANNEL1_PULSE  = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CONTINUOUS_MASK = 2'd3;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] command;
        logic                 channel;
    } cmd_item_t;

    typedef struct packed {
        logic [MASK_WIDTH-1:0]     fired_mask;
        logic                      irq;
        logic                      pending_flag;
        logic [MASK_WIDTH-1:0]     enabled_mask;
        logic                      busy_res;
        logic [COUNT_OUT_BITS-1:0] count_now;
    } res_item_t;

    typedef struct packed {
        logic [REG_WIDTH-1:0]                  default_period;
        logic [PULSE_REGS-1:0][REG_WIDTH-1:0]  pulse;
        logic [MASK_WIDTH-1:0]                 continuous_mask;
    } cfg_regs_t;

endpackage

`default_nettype wire

[rtl/pat_stream_if.sv]
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; used with the structs of pat_pkg.
`default_nettype none

interface pat_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/pat_cfg_regs.sv]
// Configuration register file of the periodic alarm timer.
// Depends on pat_pkg for the register indexes and the cfg_regs_t struct.
`default_nettype none

module pat_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [pat_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [pat_pkg::REG_WIDTH-1:0]      cfg_data,
    output pat_pkg::cfg_regs_t                      regs
);
    import pat_pkg::*;

    cfg_regs_t regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEFAULT_PERIOD:  regs_reg.default_period  <= cfg_data;
                REG_CHANNEL0_PULSE:  regs_reg.pulse[0]        <= cfg_data;
                REG_CHANNEL1_PULSE:  regs_reg.pulse[1]        <= cfg_data;
                REG_CONTINUOUS_MASK: regs_reg.continuous_mask <= cfg_data[MASK_WIDTH-1:0];
                default:             regs_reg <= regs_reg;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

[rtl/pat_in_stage.sv]
// Input register stage: captures one command item per transfer.
// Depends on pat_pkg and pat_stream_if.
`default_nettype none

module pat_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    pat_stream_if.sink          cmd,
    input  wire logic           take,
    output logic                item_valid,
    output pat_pkg::cmd_item_t  item
);
    import pat_pkg::*;

    logic      valid_reg;
    cmd_item_t item_reg;

    // Accept whenever the held item is empty or leaves this cycle
    assign cmd.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            item_reg <= cmd.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/pat_core.sv]
// Timer state, compare-match logic and result register.
// Depends on pat_pkg and pat_stream_if.
`default_nettype none

module pat_core #(
    parameter int CHANNELS      = pat_pkg::CHANNELS_DEFAULT,
    parameter int COUNTER_WIDTH = pat_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pat_pkg::cfg_regs_t  cfg,
    input  wire logic                item_valid,
    input  wire pat_pkg::cmd_item_t  item,
    output logic                     take,
    pat_stream_if.source             res
);
    import pat_pkg::*;

    localparam int CW = COUNTER_WIDTH;

    logic [CW-1:0]       count_reg, count_next, count_inc, base;
    logic [CW-1:0]       target_reg  [CHANNELS];
    logic [CW-1:0]       target_next [CHANNELS];
    logic [CW-1:0]       interval    [CHANNELS];
    logic [CW-1:0]       sum         [CHANNELS];
    logic [CHANNELS-1:0] armed_reg, armed_next;
    logic [CHANNELS-1:0] running_reg, running_next;
    logic [CHANNELS-1:0] fire;
    logic                pending_reg, pending_next, pend_out;
    logic                res_valid_reg;
    res_item_t           res_reg, res_next;

    // Advance when the result slot is free or being drained
    assign take = item_valid && (!res_valid_reg || res.ready);

    always_comb
    begin
        count_inc    = count_reg + CW'(1);
        base         = (item.command == CMD_TICK) ? count_inc : count_reg;
        count_next   = count_reg;
        armed_next   = armed_reg;
        running_next = running_reg;
        pending_next = pending_reg;
        fire         = '0;
        for (int n = 0; n < CHANNELS; n++)
        begin
            interval[n]    = CW'((cfg.pulse[n] != '0) ? cfg.pulse[n] : cfg.default_period);
            sum[n]         = base + interval[n];
            target_next[n] = target_reg[n];
        end

        unique case (item.command)
            CMD_TICK:
            begin
                count_next = count_inc;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (armed_reg[n] && (target_reg[n] == count_inc))
                    begin
                        fire[n] = 1'b1;
                        if (running_reg[n] && cfg.continuous_mask[n])
                        begin
                            target_next[n] = sum[n];
                        end
                        else
                        begin
                            armed_next[n]   = 1'b0;
                            running_next[n] = 1'b0;
                        end
                    end
                end
                if (fire != '0)
                begin
                    pending_next = 1'b1;
                end
            end
            CMD_START:
            begin
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (int'(item.channel) == n)
                    begin
                        target_next[n]  = sum[n];
                        armed_next[n]   = 1'b1;
                        running_next[n] = 1'b1;
                    end
                end
            end
            CMD_STOP:
            begin
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (int'(item.channel) == n)
                    begin
                        armed_next[n]   = 1'b0;
                        running_next[n] = 1'b0;
                    end
                end
            end
            CMD_CLEAR:
            begin
                pending_next = 1'b0;
            end
            CMD_SHUTDOWN:
            begin
                armed_next   = '0;
                running_next = '0;
                pending_next = 1'b0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        // Clear reports the flag as it stood before clearing
        pend_out = (item.command == CMD_CLEAR) ? pending_reg : pending_next;

        res_next.fired_mask   = MASK_WIDTH'(fire);
        res_next.irq          = (fire != '0);
        res_next.pending_flag = pend_out;
        res_next.enabled_mask = MASK_WIDTH'(running_next);
        res_next.busy_res     = (running_next != '0);
        res_next.count_now    = COUNT_OUT_BITS'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            armed_reg     <= '0;
            running_reg   <= '0;
            pending_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int n = 0; n < CHANNELS; n++)
            begin
                target_reg[n] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                armed_reg     <= armed_next;
                running_reg   <= running_next;
                pending_reg   <= pending_next;
                res_valid_reg <= 1'b1;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    target_reg[n] <= target_next[n];
                end
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

endmodule

`default_nettype wire

[rtl/periodic_alarm_timer.sv]
// Top level of the periodic alarm timer: config registers, input stage, core.
// Depends on pat_pkg, pat_stream_if, pat_cfg_regs, pat_in_stage and pat_core.
`default_nettype none

// Compare-match alarm timer with auto-reload. A free-running tick counter of
// COUNTER_WIDTH bits serves CHANNELS alarm channels. Each command item (tick,
// start, stop, clear pending, shutdown) produces exactly one result item that
// reports the fired channels, irq, the sticky pending flag, the running
// channels and the low 32 bits of the counter. The block takes one item per
// clock while the result side is ready: a command is captured in an input
// register at its transfer, all of its work (counter increment, one adder and
// one equality compare per channel, flag update) is done combinationally
// from that register and lands in the result register when the core takes
// the item. While a result waits to be taken, the input register accepts
// one more command and then the command side stalls; its ready follows the
// result side's ready in the same cycle.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// and should only be changed while no command is in flight.

module periodic_alarm_timer #(
    parameter int CHANNELS      = pat_pkg::CHANNELS_DEFAULT,
    parameter int COUNTER_WIDTH = pat_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [pat_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [pat_pkg::REG_WIDTH-1:0]      cfg_data,
    pat_stream_if.sink                              cmd,
    pat_stream_if.source                            res
);
    import pat_pkg::*;

    cfg_regs_t cfg;
    cmd_item_t item;
    logic      item_valid;
    logic      take;

    // Hold the programmed intervals and reload mask
    pat_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    // Capture one command per transfer; advance when the core takes it
    pat_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Update counter, targets and flags; drive the result register
    pat_core #(
        .CHANNELS      (CHANNELS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res        (res)
    );

endmodule

`default_nettype wire
